FILE: hw/rtl/srrb_pkg.sv
// Shared constants, codes and types for the sequenced replay ring buffer.
package srrb_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = $clog2(2 * DEPTH + 1);
  localparam int SEQ_W   = 32;
  localparam int PAY_W   = 32;
  localparam int FILL_W  = 5;
  localparam int STAT_W  = 3;

  typedef enum logic [0:0] {
    CMD_PUSH   = 1'b0,
    CMD_REPLAY = 1'b1
  } command_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_PUSH_OK     = 3'd0,
    STAT_PUSH_REJECT = 3'd1,
    STAT_REPLAY      = 3'd2,
    STAT_NOTHING     = 3'd3,
    STAT_RANGE       = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  // store access requested by the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [SEQ_W-1:0] wseq;
    logic [PAY_W-1:0] wpay;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [SEQ_W-1:0]  seq_out;
    logic [PAY_W-1:0]  payload_out;
    logic              last;
    logic [SEQ_W-1:0]  newest_seq;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

endpackage

FILE: hw/rtl/srrb_if.sv
// Input and result channel interfaces of the sequenced replay ring buffer.
interface srrb_in_if;
  logic                      valid;
  logic                      ready;
  logic [0:0]                command;
  logic [srrb_pkg::SEQ_W-1:0] seq;
  logic [srrb_pkg::PAY_W-1:0] payload;

  modport source (output valid, output command, output seq, output payload, input ready);
  modport sink   (input valid, input command, input seq, input payload, output ready);
endinterface

interface srrb_out_if;
  logic                        valid;
  logic                        ready;
  logic [srrb_pkg::STAT_W-1:0] status;
  logic [srrb_pkg::SEQ_W-1:0]  seq_out;
  logic [srrb_pkg::PAY_W-1:0]  payload_out;
  logic                        last;
  logic [srrb_pkg::SEQ_W-1:0]  newest_seq;
  logic [srrb_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, output status, output seq_out, output payload_out,
                  output last, output newest_seq, output fill_count, input ready);
  modport sink   (input valid, input status, input seq_out, input payload_out,
                  input last, input newest_seq, input fill_count, output ready);
endinterface

FILE: hw/rtl/sequenced_replay_ring_buffer.sv
// Top level of the sequenced replay ring buffer.
// Replay buffer of DEPTH (16) entries, each a 32-bit sequence number and a
// 32-bit payload handle. A push (command 0) writes the next ring slot,
// overwriting the oldest entry once full, and is rejected when a nonzero
// newest sequence is already set and the new one is not strictly greater.
// A replay (command 1) with sequence s returns every held entry newer than
// s, oldest first, with last set on the final one; otherwise a single
// result reports nothing newer or out of range. Every result carries the
// newest sequence and the fill count after the step. A replay run holds
// the input while it lasts: the first entry is fetched from the store,
// then one entry per cycle follows while the result slot is free, paced
// by the single read port of the entry store. A new command is taken
// only while the result register is empty or its result transfers in
// that same cycle, so a result held by the receiver stalls the input.
module sequenced_replay_ring_buffer (
  input  logic              clk,
  input  logic              rst_n,
  srrb_in_if.sink           in_bus,
  srrb_out_if.source        out_bus
);

  srrb_pkg::mem_req_t           mem_req;
  srrb_pkg::out_item_t          item;
  srrb_pkg::out_item_t          item_r;
  logic [srrb_pkg::SEQ_W-1:0]   rd_seq;
  logic [srrb_pkg::PAY_W-1:0]   rd_pay;
  logic                         out_valid_r;
  logic                         out_free;
  logic                         out_load;

  // result slot is free when empty or emptied by this cycle's transfer
  assign out_free = !out_valid_r || out_bus.ready;

  srrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_command (in_bus.command),
    .in_seq     (in_bus.seq),
    .in_payload (in_bus.payload),
    .out_free   (out_free),
    .out_load   (out_load),
    .out_item   (item),
    .mem_req    (mem_req),
    .rd_seq     (rd_seq),
    .rd_pay     (rd_pay)
  );

  srrb_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .rd_seq (rd_seq),
    .rd_pay (rd_pay)
  );

  // result register: control bit reset, payload not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      item_r <= item;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = item_r.status;
  assign out_bus.seq_out     = item_r.seq_out;
  assign out_bus.payload_out = item_r.payload_out;
  assign out_bus.last        = item_r.last;
  assign out_bus.newest_seq  = item_r.newest_seq;
  assign out_bus.fill_count  = item_r.fill_count;

endmodule

FILE: hw/rtl/srrb_store.sv
// Entry store: one write port, one read port with registered read data.
module srrb_store (
  input  logic                        clk,
  input  srrb_pkg::mem_req_t          req,
  output logic [srrb_pkg::SEQ_W-1:0]  rd_seq,
  output logic [srrb_pkg::PAY_W-1:0]  rd_pay
);

  logic [srrb_pkg::SEQ_W-1:0] seq_mem [srrb_pkg::DEPTH];
  logic [srrb_pkg::PAY_W-1:0] pay_mem [srrb_pkg::DEPTH];
  logic [srrb_pkg::SEQ_W-1:0] rd_seq_r;
  logic [srrb_pkg::PAY_W-1:0] rd_pay_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      seq_mem[req.waddr] <= req.wseq;
      pay_mem[req.waddr] <= req.wpay;
    end
    if (req.re) begin
      rd_seq_r <= seq_mem[req.raddr];
      rd_pay_r <= pay_mem[req.raddr];
    end
  end

  assign rd_seq = rd_seq_r;
  assign rd_pay = rd_pay_r;

endmodule

FILE: hw/rtl/srrb_ctrl.sv
// Sequencer: push/replay checks, ring pointers and the replay walk.
module srrb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [0:0]                  in_command,
  input  logic [srrb_pkg::SEQ_W-1:0]  in_seq,
  input  logic [srrb_pkg::PAY_W-1:0]  in_payload,
  input  logic                        out_free,
  output logic                        out_load,
  output srrb_pkg::out_item_t         out_item,
  output srrb_pkg::mem_req_t          mem_req,
  input  logic [srrb_pkg::SEQ_W-1:0]  rd_seq,
  input  logic [srrb_pkg::PAY_W-1:0]  rd_pay
);

  localparam logic [srrb_pkg::IDX_W-1:0] LAST_IDX = srrb_pkg::IDX_W'(srrb_pkg::DEPTH - 1);
  localparam logic [srrb_pkg::CNT_W-1:0] FULL_CNT = srrb_pkg::CNT_W'(srrb_pkg::DEPTH);
  localparam logic [srrb_pkg::SUM_W-1:0] DEPTH_S  = srrb_pkg::SUM_W'(srrb_pkg::DEPTH);

  srrb_pkg::state_t             state_r, state_nxt;
  logic [srrb_pkg::IDX_W-1:0]   wslot_r, wslot_nxt;
  logic [srrb_pkg::CNT_W-1:0]   held_r, held_nxt;
  logic [srrb_pkg::SEQ_W-1:0]   newest_r, newest_nxt;
  logic [srrb_pkg::IDX_W-1:0]   rdidx_r, rdidx_nxt;
  logic [srrb_pkg::CNT_W-1:0]   remain_r, remain_nxt;

  logic                         accept;
  logic [srrb_pkg::SEQ_W-1:0]   diff;
  logic                         reject, range_bad, nothing;
  logic [srrb_pkg::CNT_W-1:0]   count;
  logic [srrb_pkg::SUM_W-1:0]   start_sum;
  logic [srrb_pkg::IDX_W-1:0]   start_idx;

  function automatic logic [srrb_pkg::IDX_W-1:0] next_idx(input logic [srrb_pkg::IDX_W-1:0] i);
    next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign in_ready = (state_r == srrb_pkg::S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // newest minus the requested sequence, shared by the range check and the run count
  assign diff      = newest_r - in_seq;
  assign reject    = (newest_r != '0) && (in_seq <= newest_r);
  assign range_bad = (held_r == '0) || (in_seq > newest_r) ||
                     (diff > srrb_pkg::SEQ_W'(held_r));
  assign nothing   = (in_seq == newest_r);
  assign count     = diff[srrb_pkg::CNT_W-1:0];
  assign start_sum = srrb_pkg::SUM_W'(wslot_r) + DEPTH_S - srrb_pkg::SUM_W'(count);
  assign start_idx = (start_sum >= DEPTH_S) ? srrb_pkg::IDX_W'(start_sum - DEPTH_S)
                                            : srrb_pkg::IDX_W'(start_sum);

  always_comb begin
    state_nxt  = state_r;
    wslot_nxt  = wslot_r;
    held_nxt   = held_r;
    newest_nxt = newest_r;
    rdidx_nxt  = rdidx_r;
    remain_nxt = remain_r;
    out_load   = 1'b0;
    mem_req    = '0;
    mem_req.waddr = wslot_r;
    mem_req.wseq  = in_seq;
    mem_req.wpay  = in_payload;
    mem_req.raddr = rdidx_r;

    case (state_r)
      srrb_pkg::S_IDLE: begin
        if (accept) begin
          if (in_command == srrb_pkg::CMD_PUSH) begin
            out_load = 1'b1;
            if (!reject) begin
              mem_req.we = 1'b1;
              wslot_nxt  = next_idx(wslot_r);
              held_nxt   = (held_r == FULL_CNT) ? held_r : held_r + 1'b1;
              newest_nxt = in_seq;
            end
          end else if (range_bad || nothing) begin
            out_load = 1'b1;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = start_idx;
            rdidx_nxt     = next_idx(start_idx);
            remain_nxt    = count;
            state_nxt     = srrb_pkg::S_EMIT;
          end
        end
      end
      srrb_pkg::S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          remain_nxt = remain_r - 1'b1;
          if (remain_r == srrb_pkg::CNT_W'(1)) begin
            state_nxt = srrb_pkg::S_IDLE;
          end else begin
            mem_req.re = 1'b1;
            rdidx_nxt  = next_idx(rdidx_r);
          end
        end
      end
      default: begin
        state_nxt = srrb_pkg::S_IDLE;
      end
    endcase
  end

  // result fields; newest and fill reflect the state after this step
  always_comb begin
    out_item.newest_seq = newest_nxt;
    out_item.fill_count = srrb_pkg::FILL_W'(held_nxt);
    if (state_r == srrb_pkg::S_EMIT) begin
      out_item.status      = srrb_pkg::STAT_REPLAY;
      out_item.seq_out     = rd_seq;
      out_item.payload_out = rd_pay;
      out_item.last        = (remain_r == srrb_pkg::CNT_W'(1));
    end else begin
      out_item.seq_out     = '0;
      out_item.payload_out = '0;
      out_item.last        = 1'b1;
      if (in_command == srrb_pkg::CMD_PUSH) begin
        out_item.status = reject ? srrb_pkg::STAT_PUSH_REJECT : srrb_pkg::STAT_PUSH_OK;
      end else begin
        out_item.status = range_bad ? srrb_pkg::STAT_RANGE : srrb_pkg::STAT_NOTHING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= srrb_pkg::S_IDLE;
      wslot_r  <= '0;
      held_r   <= '0;
      newest_r <= '0;
      rdidx_r  <= '0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      wslot_r  <= wslot_nxt;
      held_r   <= held_nxt;
      newest_r <= newest_nxt;
      rdidx_r  <= rdidx_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

FILE: sim/srrb_result_checker.sv
// Result checker for the sequenced replay ring buffer: predicts and compares every transfer.
`timescale 1ns / 100ps
module srrb_result_checker
  import srrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [0:0]        in_command,
  input  logic [SEQ_W-1:0]  in_seq,
  input  logic [PAY_W-1:0]  in_payload,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [STAT_W-1:0] out_status,
  input  logic [SEQ_W-1:0]  out_seq_out,
  input  logic [PAY_W-1:0]  out_payload_out,
  input  logic              out_last,
  input  logic [SEQ_W-1:0]  out_newest_seq,
  input  logic [FILL_W-1:0] out_fill_count,
  output int                mismatch_count,
  output int                pending_results,
  output int                results_checked,
  output int                replay_entries,
  output int                input_stall_cycles
);

  // shadow of the ring contents and pointers
  logic [SEQ_W-1:0]  ring_seq [DEPTH];
  logic [PAY_W-1:0]  ring_pay [DEPTH];
  logic [IDX_W-1:0]  next_slot;
  logic [FILL_W-1:0] held;
  logic [SEQ_W-1:0]  newest;

  out_item_t awaited_results [$];

  function automatic out_item_t status_only(status_t st);
    out_item_t r;
    r.status      = st;
    r.seq_out     = '0;
    r.payload_out = '0;
    r.last        = 1'b1;
    r.newest_seq  = newest;
    r.fill_count  = held;
    return r;
  endfunction

  // append one predicted result at the tail
  task automatic queue_result(out_item_t r);
    awaited_results.insert(awaited_results.size(), r);
  endtask

  task automatic predict_command(command_t cmd, logic [SEQ_W-1:0] s, logic [PAY_W-1:0] p);
    logic [SEQ_W-1:0] span;
    logic [IDX_W-1:0] idx;
    out_item_t        r;
    int               k;
    if (cmd == CMD_PUSH) begin
      if (newest != '0 && s <= newest) begin
        queue_result(status_only(STAT_PUSH_REJECT));
      end else begin
        ring_seq[next_slot] = s;
        ring_pay[next_slot] = p;
        next_slot = next_slot + 1'b1;
        if (held < DEPTH) held = held + 1'b1;
        newest = s;
        queue_result(status_only(STAT_PUSH_OK));
      end
    end else if (held == '0 || s > newest || (newest - s) > held) begin
      queue_result(status_only(STAT_RANGE));
    end else if (s == newest) begin
      queue_result(status_only(STAT_NOTHING));
    end else begin
      span = newest - s;
      // span never exceeds DEPTH, so the low bits give the ring offset
      idx  = next_slot - span[IDX_W-1:0];
      for (k = 0; k < span; k++) begin
        r             = status_only(STAT_REPLAY);
        r.seq_out     = ring_seq[idx];
        r.payload_out = ring_pay[idx];
        r.last        = (k + 1 == span);
        queue_result(r);
        replay_entries++;
        idx = idx + 1'b1;
      end
    end
  endtask

  task automatic check_result();
    out_item_t want;
    results_checked++;
    if (awaited_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: status %0d seq %h pay %h last %b newest %h fill %0d",
                 out_status, out_seq_out, out_payload_out, out_last, out_newest_seq,
                 out_fill_count);
    end else begin
      want = awaited_results.pop_front();
      if (want.status !== out_status || want.seq_out !== out_seq_out ||
          want.payload_out !== out_payload_out || want.last !== out_last ||
          want.newest_seq !== out_newest_seq || want.fill_count !== out_fill_count) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch at result %0d", results_checked);
          $display("  expected status %0d seq %h pay %h last %b newest %h fill %0d",
                   want.status, want.seq_out, want.payload_out, want.last,
                   want.newest_seq, want.fill_count);
          $display("  actual   status %0d seq %h pay %h last %b newest %h fill %0d",
                   out_status, out_seq_out, out_payload_out, out_last, out_newest_seq,
                   out_fill_count);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      next_slot = '0;
      held      = '0;
      newest    = '0;
      awaited_results.delete();
    end else begin
      // retire first: a result leaving now belongs to an earlier command
      if (out_valid === 1'b1 && out_ready === 1'b1) check_result();
      if (in_valid === 1'b1 && in_ready === 1'b1)
        predict_command(command_t'(in_command), in_seq, in_payload);
      if (in_valid === 1'b1 && in_ready !== 1'b1) input_stall_cycles++;
    end
    pending_results = awaited_results.size();
  end

endmodule

FILE: sim/tb_sequenced_replay_ring_buffer.sv
// Testbench top for the sequenced replay ring buffer: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_sequenced_replay_ring_buffer;
  import srrb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 128;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;

  srrb_in_if  in_ch ();
  srrb_out_if out_ch ();

  // idling mix, changed per phase by the stimulus process
  int send_idle_pct;
  int recv_idle_pct;
  // set by the stimulus to request a receiver hold-off
  bit hold_off_request;

  // stimulus-side view of the newest sequence and fill, used only to
  // shape commands around the current sequence range
  logic [SEQ_W-1:0] shape_newest;
  int               shape_held;

  int pushes_sent;
  int replays_sent;
  int cycle_count;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int replay_entries;
  int input_stall_cycles;

  sequenced_replay_ring_buffer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  srrb_result_checker result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_command         (in_ch.command),
    .in_seq             (in_ch.seq),
    .in_payload         (in_ch.payload),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_seq_out        (out_ch.seq_out),
    .out_payload_out    (out_ch.payload_out),
    .out_last           (out_ch.last),
    .out_newest_seq     (out_ch.newest_seq),
    .out_fill_count     (out_ch.fill_count),
    .mismatch_count     (mismatch_count),
    .pending_results    (pending_results),
    .results_checked    (results_checked),
    .replay_entries     (replay_entries),
    .input_stall_cycles (input_stall_cycles)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, pending_results);
      $display("tb_sequenced_replay_ring_buffer: done, errors");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off on request. The
  // hold-off is counted here so the sender keeps offering meanwhile and
  // the result register stays full and the block stalls its input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one command and wait for its transfer. Called at a rising edge and
  // returns at the edge of the transfer, so valid only moves once per edge.
  task automatic offer_command(input command_t cmd, input logic [SEQ_W-1:0] s,
                               input logic [PAY_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.seq     <= s;
    in_ch.payload <= p;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (cmd == CMD_PUSH) begin
      pushes_sent++;
      if (shape_newest == '0 || s > shape_newest) begin
        shape_newest = s;
        if (shape_held < DEPTH) shape_held++;
      end
    end else begin
      replays_sent++;
    end
  endtask

  // Stop offering until every awaited result has been transferred.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  // Mostly consecutive pushes and in-range replays; the rest probes the
  // range edges, stale pushes, sequence jumps and plain noise.
  task automatic pick_random_item(output command_t cmd, output logic [SEQ_W-1:0] s,
                                  output logic [PAY_W-1:0] p);
    int r;
    r = $urandom_range(99);
    p = $urandom();
    if (r < 48) begin
      cmd = CMD_PUSH;
      s   = shape_newest + 1;
    end else if (r < 78) begin
      cmd = CMD_REPLAY;
      s   = shape_newest - $urandom_range(0, shape_held);
    end else if (r < 84) begin
      // just past the oldest entry
      cmd = CMD_REPLAY;
      s   = shape_newest - shape_held - $urandom_range(1, 3);
    end else if (r < 88) begin
      // ahead of the newest
      cmd = CMD_REPLAY;
      s   = shape_newest + $urandom_range(1, 3);
    end else if (r < 92) begin
      // equal or older: rejected once the check is armed
      cmd = CMD_PUSH;
      s   = shape_newest - $urandom_range(0, 3);
    end else if (r < 96) begin
      cmd = CMD_REPLAY;
      s   = $urandom();
    end else if (r < 98) begin
      // gap in the sequence
      cmd = CMD_PUSH;
      s   = shape_newest + $urandom_range(2, 64);
    end else begin
      cmd = CMD_PUSH;
      s   = $urandom();
    end
  endtask

  initial begin
    int               ph;
    int               n;
    command_t         cmd;
    logic [SEQ_W-1:0] s;
    logic [PAY_W-1:0] p;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_PUSH;
    in_ch.seq        <= '0;
    in_ch.payload    <= '0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_off_request = 1'b0;
    shape_newest     = '0;
    shape_held       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part -------------------------------------------------
    send_idle_pct = 27;
    recv_idle_pct = 67;
    offer_command(CMD_REPLAY, 32'd0, 32'h0000_0000);        // replay on an empty store
    offer_command(CMD_PUSH, 32'd0, 32'h0000_0000);          // first push of 0: check stays off
    offer_command(CMD_PUSH, 32'd0, 32'hFFFF_FFFF);          // second 0 still taken
    offer_command(CMD_REPLAY, 32'd0, 32'hFFFF_FFFF);        // equal to newest: nothing newer
    offer_command(CMD_PUSH, 32'd1, 32'hA5A5_A5A5);          // arms the order check
    offer_command(CMD_PUSH, 32'd1, 32'h5A5A_5A5A);          // equal: rejected
    offer_command(CMD_PUSH, 32'd0, 32'h1234_5678);          // older: rejected
    offer_command(CMD_REPLAY, 32'd0, 32'h0);                // run of one
    offer_command(CMD_REPLAY, 32'hFFFF_FFFF, 32'h0);        // far ahead of newest
    // fill the ring and wrap it
    for (n = 2; n <= 17; n++) offer_command(CMD_PUSH, n, $urandom());
    offer_command(CMD_REPLAY, 32'd1, 32'h0);                // full-depth run
    offer_command(CMD_REPLAY, 32'd0, 32'h0);                // one beyond the replay range
    wait_for_drain();

    // --- random part, three idling mixes ------------------------------
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // jump the sequence so accepted pushes reach the upper bits
      if (ph > 0) offer_command(CMD_PUSH, shape_newest + 32'h3000_0000, $urandom());
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering
        if ((ph == 0 && n == 40) || (ph == 2 && n == 70)) hold_off_request = 1'b1;
        pick_random_item(cmd, s, p);
        offer_command(cmd, s, p);
      end
      // sender pause until everything awaited has been transferred
      wait_for_drain();
    end

    // --- top of the sequence space --------------------------------------
    offer_command(CMD_PUSH, 32'hFFFF_FFFF, $urandom());      // largest sequence
    offer_command(CMD_REPLAY, 32'hFFFF_FFFF, $urandom());    // nothing newer
    offer_command(CMD_REPLAY, 32'hFFFF_FFFE, $urandom());    // single-entry run
    offer_command(CMD_PUSH, 32'hFFFF_FFFF, $urandom());      // equal: rejected
    offer_command(CMD_PUSH, 32'd0, $urandom());              // wrap attempt: rejected
    offer_command(CMD_REPLAY, 32'd0, $urandom());            // huge distance, no wrap
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d pushes and %0d replays sent, %0d results checked, %0d replayed",
             pushes_sent, replays_sent, results_checked, replay_entries);
    $display("summary: three idling mixes, receiver hold-offs, %0d input stall cycles seen",
             input_stall_cycles);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb_sequenced_replay_ring_buffer: done, clean");
    end else begin
      $display("tb_sequenced_replay_ring_buffer: done, errors");
    end
    $finish;
  end

endmodule
